// File: rtl/core/stack_machine_arith_unit_top_assert.svh
// Assertion macros for the stack machine arithmetic unit.
`ifndef STACK_MACHINE_ARITH_UNIT_TOP_ASSERT_SVH
`define STACK_MACHINE_ARITH_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SMAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smau: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define SMAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smau: next-cycle check failed");

`endif

// File: rtl/core/smau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smau_pkg;

    localparam int WORD_W  = 32;
    localparam int DEPTH_W = 7;
    localparam int CNT_W   = $clog2(WORD_W);

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_DIV  = 3'd3,
        OP_MUL  = 3'd4,
        OP_MOD  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_WAIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_alu_rsp;

endpackage

`default_nettype wire

// File: rtl/core/smau_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module smau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/smau_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module smau_alu
    import smau_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    output t_alu_rsp               o_rsp
);

    logic              r_busy;
    logic              r_done;
    t_op               r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic              r_neg_q;
    logic              r_neg_r;

    logic [WORD_W-1:0] w_abs_a;
    logic [WORD_W-1:0] w_abs_b;
    logic [WORD_W-1:0] w_sh;
    logic [WORD_W-1:0] w_lhs;
    logic [WORD_W-1:0] w_rhs;
    logic              w_cin;
    logic [WORD_W:0]   w_sum;

    assign w_abs_a = i_a[WORD_W-1] ? (~i_a + WORD_W'(1)) : i_a;
    assign w_abs_b = i_b[WORD_W-1] ? (~i_b + WORD_W'(1)) : i_b;
    assign w_sh    = {r_acc[WORD_W-2:0], r_x[WORD_W-1]};

    // one shared adder: add, subtract, shift-add multiply, restoring divide
    always_comb begin
        w_lhs = r_acc;
        w_rhs = r_y;
        w_cin = 1'b0;
        unique case (r_op)
            OP_SUB: begin
                w_rhs = ~r_y;
                w_cin = 1'b1;
            end
            OP_MUL: begin
                w_rhs = r_y[0] ? r_x : '0;
            end
            OP_DIV, OP_MOD: begin
                w_lhs = w_sh;
                w_rhs = ~r_y;
                w_cin = 1'b1;
            end
            default: begin
                w_rhs = r_y;
            end
        endcase
    end

    assign w_sum = {1'b0, w_lhs} + {1'b0, w_rhs} + {{WORD_W{1'b0}}, w_cin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op    <= i_req.op;
            r_neg_q <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
            r_neg_r <= i_a[WORD_W-1];
            unique case (i_req.op)
                OP_MUL: begin
                    r_acc <= '0;
                    r_x   <= i_a;
                    r_y   <= i_b;
                    r_cnt <= CNT_W'(WORD_W - 1);
                end
                OP_DIV, OP_MOD: begin
                    r_acc <= '0;
                    r_x   <= w_abs_a;
                    r_y   <= w_abs_b;
                    r_cnt <= CNT_W'(WORD_W - 1);
                end
                default: begin
                    r_acc <= i_a;
                    r_x   <= '0;
                    r_y   <= i_b;
                    r_cnt <= '0;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            unique case (r_op)
                OP_MUL: begin
                    r_acc <= w_sum[WORD_W-1:0];
                    r_x   <= {r_x[WORD_W-2:0], 1'b0};
                    r_y   <= {1'b0, r_y[WORD_W-1:1]};
                end
                OP_DIV, OP_MOD: begin
                    r_acc <= w_sum[WORD_W] ? w_sum[WORD_W-1:0] : w_sh;
                    r_x   <= {r_x[WORD_W-2:0], w_sum[WORD_W]};
                end
                default: begin
                    r_acc <= w_sum[WORD_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        unique case (r_op)
            OP_DIV:  o_rsp.result = r_neg_q ? (~r_x + WORD_W'(1)) : r_x;
            OP_MOD:  o_rsp.result = r_neg_r ? (~r_acc + WORD_W'(1)) : r_acc;
            default: o_rsp.result = r_acc;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/stack_machine_arith_unit_top.sv
// Stack machine arithmetic unit: bounded stack of signed 32-bit words.
// Input channel: i_valid / o_stall carry one instruction word (i_op,
// i_push_value); a word is taken when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall carry one result word per instruction
// (o_status, o_top_value, o_stack_depth); taken when o_valid and !i_stall.
// Path from accept to o_valid: push, errors and unused ops pass S_DECODE
// and S_RESP; add, sub, mul, div and mod pass S_DECODE, S_READ, S_WAIT and
// S_RESP, where mul, div and mod run 32 steps of the shared shift/add unit.
// The block works on one word at a time; o_stall is high from the cycle
// after accept until the result enters the output register. A stalled
// result holds in that register, and the next word can be accepted while
// it waits; a further result waits in the sequencer until the register
// frees up.
// The top entry lives in a register; deeper entries live in a one-write,
// one-read RAM with registered read.
// Reset empties the stack and clears the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_arith_unit_top
    import smau_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [2:0]                i_op,
    input  wire logic signed [WORD_W-1:0]  i_push_value,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [1:0]                     o_status,
    output logic signed [WORD_W-1:0]       o_top_value,
    output logic [DEPTH_W-1:0]             o_stack_depth
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state            r_state;
    t_state            n_state;
    t_op               r_op;
    logic [WORD_W-1:0] r_pv;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [WORD_W-1:0] r_top;
    logic [WORD_W-1:0] n_top;
    t_status           r_status;
    t_status           n_status;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_top;
    logic [DEPTH_W-1:0] r_out_depth;

    logic              w_accept;
    logic              w_is_bin;
    logic              w_short;
    logic              w_divz;
    logic              w_full;
    logic              w_go;
    logic              w_load;
    logic [CW-1:0]     w_cm1;
    logic [CW-1:0]     w_cm2;
    logic [CW+DEPTH_W-1:0] w_cnt_ext;
    logic              w_we;
    logic              w_re;
    logic [WORD_W-1:0] w_rdata;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_is_bin = (r_op == OP_ADD) || (r_op == OP_SUB) || (r_op == OP_DIV)
                   || (r_op == OP_MUL) || (r_op == OP_MOD);
    assign w_short  = (r_count < CW'(2));
    assign w_divz   = ((r_op == OP_DIV) || (r_op == OP_MOD)) && (r_top == '0);
    assign w_full   = (r_count == CW'(STACK_DEPTH));
    assign w_go     = w_is_bin && !w_short && !w_divz;
    assign w_cm1    = r_count - CW'(1);
    assign w_cm2    = r_count - CW'(2);
    assign w_load   = (r_state == S_RESP) && (!r_out_valid || !i_stall);
    assign w_cnt_ext = {{DEPTH_W{1'b0}}, r_count};

    smau_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cm1[AW-1:0]),
        .i_wdata (r_top),
        .i_re    (w_re),
        .i_raddr (w_cm2[AW-1:0]),
        .o_rdata (w_rdata)
    );

    smau_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (w_rdata),
        .i_b     (r_top),
        .o_rsp   (w_alu_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_DECODE;
            S_DECODE: n_state = w_go ? S_READ : S_RESP;
            S_READ:   n_state = S_WAIT;
            S_WAIT:   if (w_alu_rsp.done) n_state = S_RESP;
            S_RESP:   if (w_load) n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_we          = 1'b0;
        w_re          = 1'b0;
        w_alu_req     = '{start: 1'b0, op: r_op};
        n_top         = r_top;
        n_count       = r_count;
        n_status      = r_status;
        unique case (r_state)
            S_DECODE: begin
                n_status = ST_OK;
                if (r_op == OP_PUSH) begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_we    = (r_count != '0);
                        n_top   = r_pv;
                        n_count = r_count + CW'(1);
                    end
                end else if (w_is_bin) begin
                    priority if (w_short) begin
                        n_status = ST_SHORT;
                    end else if (w_divz) begin
                        n_status = ST_DIVZERO;
                    end else begin
                        w_re = 1'b1;
                    end
                end
            end
            S_READ: begin
                w_alu_req.start = 1'b1;
            end
            S_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_top   = w_alu_rsp.result;
                    n_count = w_cm1;
                end
            end
            S_IDLE, S_RESP: begin
                n_top = r_top;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_status <= n_status;
        if (w_accept) begin
            r_op <= t_op'(i_op);
            r_pv <= i_push_value;
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_top    <= (r_count == '0) ? '0 : r_top;
            r_out_depth  <= w_cnt_ext[DEPTH_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_top_value   = r_out_top;
    assign o_stack_depth = r_out_depth;

`include "stack_machine_arith_unit_top_assert.svh"

    `SMAU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    `SMAU_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, w_alu_rsp.done, r_state == S_WAIT)
    `SMAU_ASSERT_NEXT(a_pop_on_done, i_clk, i_rst_n, w_alu_rsp.done, r_count == $past(w_cm1))
    `SMAU_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, w_accept, r_state == S_DECODE)

endmodule

`default_nettype wire

// File: sim/stack_machine_arith_unit_top_tb.sv
`timescale 1ns / 1ps

module stack_machine_arith_unit_top_tb;
    import smau_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 50;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_NEG1 = 32'hFFFF_FFFF;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] value;
    } t_instr;

    typedef struct {
        t_status     status;
        logic [31:0] top;
        logic [6:0]  depth;
    } t_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [2:0]                i_op = OP_PUSH;
    logic signed [WORD_W-1:0]  i_push_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [1:0]                o_status;
    logic signed [WORD_W-1:0]  o_top_value;
    logic [DEPTH_W-1:0]        o_stack_depth;

    stack_machine_arith_unit_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_top_value  (o_top_value),
        .o_stack_depth(o_stack_depth)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow stack
    logic [31:0] stack_mem [STACK_DEPTH];
    int          stack_count = 0;

    t_instr  instr_queue[$];
    t_result pending_results[$];

    int error_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int deepest = 0;
    int cycle_count = 0;

    function automatic t_result apply_instruction(input logic [2:0] op,
                                                  input logic [31:0] value);
        t_result     r;
        logic [31:0] a, b, ma, mb, q, rem, res;
        logic        ok;
        r.status = ST_OK;
        ok = 1'b1;
        res = '0;
        if (op == OP_PUSH) begin
            if (stack_count >= STACK_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                stack_mem[stack_count] = value;
                stack_count++;
            end
        end else if (op >= OP_ADD && op <= OP_MOD) begin
            if (stack_count < 2) begin
                r.status = ST_SHORT;
            end else begin
                b = stack_mem[stack_count-1];
                a = stack_mem[stack_count-2];
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                case (op)
                    OP_ADD: res = a + b;
                    OP_SUB: res = a - b;
                    OP_MUL: res = a * b;
                    OP_DIV: begin
                        if (b == '0) begin
                            ok = 1'b0;
                        end else begin
                            q = ma / mb;
                            res = (a[31] ^ b[31]) ? -q : q;
                        end
                    end
                    default: begin
                        if (b == '0) begin
                            ok = 1'b0;
                        end else begin
                            rem = ma % mb;
                            res = a[31] ? -rem : rem;
                        end
                    end
                endcase
                if (!ok) begin
                    r.status = ST_DIVZERO;
                end else begin
                    stack_mem[stack_count-2] = res;
                    stack_count--;
                end
            end
        end
        r.top = (stack_count > 0) ? stack_mem[stack_count-1] : '0;
        r.depth = stack_count[6:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return 32'd1;
            2: return WORD_NEG1;
            3: return WORD_MIN;
            4: return WORD_MAX;
            5, 6: return $urandom_range(0, 200) - 100;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_instr(input logic [2:0] op, input logic [31:0] value);
        t_instr it;
        it.op = op;
        it.value = value;
        instr_queue.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // sender: bursts with gaps
    t_instr  cur_instr;
    t_result next_result;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                next_result = apply_instruction(i_op, i_push_value);
                pending_results.push_back(next_result);
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (instr_queue.size() > 0) begin
                    cur_instr = instr_queue.pop_front();
                    i_op <= cur_instr.op;
                    i_push_value <= cur_instr.value;
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: runs of stall and no stall
    t_result want;
    int      run_left = 0;
    logic    stalling = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, actual %0h/%0h/%0d",
                                 $time, o_status, o_top_value, o_stack_depth);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("top_value", want.top, o_top_value);
                    check_field("stack_depth", 32'(want.depth), 32'(o_stack_depth));
                    results_checked++;
                    status_seen[o_status]++;
                    if (int'(o_stack_depth) > deepest)
                        deepest = int'(o_stack_depth);
                end
            end
            if (run_left > 0) begin
                run_left--;
            end else begin
                stalling = ~stalling;
                run_left = stalling ? $urandom_range(0, 40) : $urandom_range(0, 60);
            end
            i_stall <= stalling;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("stack_machine_arith_unit_top_tb: errors");
            $finish;
        end
    end

    initial begin
        int counted;
        int seg_left;
        int push_pct;
        int pct_table [4];
        pct_table = '{95, 75, 45, 15};

        // short stack on empty
        queue_instr(OP_ADD, $urandom());
        queue_instr(OP_MOD, $urandom());
        queue_instr(OP_PUSH, WORD_MAX);
        queue_instr(OP_DIV, $urandom());
        // add overflow wraps
        queue_instr(OP_PUSH, 32'd1);
        queue_instr(OP_ADD, $urandom());
        // most negative over minus one
        queue_instr(OP_PUSH, WORD_NEG1);
        queue_instr(OP_DIV, $urandom());
        queue_instr(OP_PUSH, WORD_NEG1);
        queue_instr(OP_MOD, $urandom());
        // zero divisor
        queue_instr(OP_PUSH, '0);
        queue_instr(OP_DIV, $urandom());
        queue_instr(OP_MOD, $urandom());
        queue_instr(OP_RSVD6, $urandom());
        queue_instr(OP_RSVD7, $urandom());
        // truncation and remainder sign
        queue_instr(OP_PUSH, -32'sd7);
        queue_instr(OP_PUSH, 32'd2);
        queue_instr(OP_DIV, $urandom());
        queue_instr(OP_PUSH, 32'd2);
        queue_instr(OP_MOD, $urandom());
        queue_instr(OP_PUSH, WORD_MIN);
        queue_instr(OP_MUL, $urandom());
        queue_instr(OP_PUSH, WORD_MAX);
        queue_instr(OP_SUB, $urandom());
        queue_instr(OP_MUL, $urandom());

        counted = 0;
        seg_left = 0;
        push_pct = 50;
        while (counted < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                push_pct = pct_table[$urandom_range(0, 3)];
                seg_left = $urandom_range(30, 120);
            end
            seg_left--;
            if ($urandom_range(0, 99) < 3) begin
                queue_instr(3'($urandom_range(OP_RSVD6, OP_RSVD7)), $urandom());
            end else begin
                if ($urandom_range(0, 99) < push_pct)
                    queue_instr(OP_PUSH, pick_word());
                else
                    queue_instr(3'($urandom_range(OP_ADD, OP_MOD)), $urandom());
                counted++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || i_valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
        end

        $display("Ran %0d instruction words, %0d results checked, deepest stack %0d.",
                 words_sent, results_checked, deepest);
        $display("Status counts ok/short/divzero/full: %0d/%0d/%0d/%0d.",
                 status_seen[ST_OK], status_seen[ST_SHORT],
                 status_seen[ST_DIVZERO], status_seen[ST_FULL]);
        if (error_count == 0) begin
            $display("stack_machine_arith_unit_top_tb: clean");
        end else begin
            $display("stack_machine_arith_unit_top_tb: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/smau_pkg.sv
rtl/core/smau_ram.sv
rtl/core/smau_alu.sv
rtl/core/stack_machine_arith_unit_top.sv
sim/stack_machine_arith_unit_top_tb.sv
